/* src/qbtc_pkg.sv */
// Shared types and constants of the queued beep tone controller.
// No dependencies; every other file of the block but qbtc_ram imports this package.
`default_nettype none

package qbtc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int DUR_W      = 16;
    localparam int FREQ_W     = 16;
    localparam int CNT_W      = 5;
    localparam int TV_W       = 16;
    localparam int CMP_W      = 15;
    localparam int NUM_W      = 28;
    localparam int DEN_W      = 16;
    localparam int ENTRY_W    = DUR_W + FREQ_W;

    localparam logic              RST_BUZZER_KIND = 1'b0;
    localparam logic [DUR_W-1:0]  RST_DEF_DUR     = 16'd200;
    localparam logic [FREQ_W-1:0] RST_DEF_FREQ    = 16'd1000;
    localparam logic [CNT_W-1:0]  RST_QUEUE_LIMIT = 5'd10;
    localparam logic [NUM_W-1:0]  RST_CLOCK_HZ    = 28'd100000000;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic KIND_PASSIVE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUZZER_KIND  = 3'd0,
        REG_DEF_DURATION = 3'd1,
        REG_DEF_FREQ     = 3'd2,
        REG_QUEUE_LIMIT  = 3'd3,
        REG_TIMER_CLOCK  = 3'd4
    } qbtc_reg_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic pop_load;
        logic div_start;
        logic div_sel;
        logic take_q;
        logic load_timer;
        logic set_ferr;
        logic load_out;
    } qbtc_cmd_t;

    typedef struct packed {
        logic start_tone;
        logic pop;
        logic passive;
        logic freq_zero;
        logic div_done;
    } qbtc_status_t;

endpackage

`default_nettype wire

/* src/queued_beep_tone_controller.sv */
// Top level of the queued beep tone controller.
// Depends on qbtc_pkg, qbtc_ctrl and qbtc_datapath.
//
// Usage:
//   s_ channel: one item per transfer, s_mode 0 is a beep request
//   (s_duration_ms, s_freq_hz, zero selects the configured default), s_mode 1
//   is a one-millisecond tick. Every item gives exactly one m_ transfer with
//   the tone state, timer values, drop and frequency error flags and the
//   number of queued beeps after that item.
//   cfg_ channel: register writes by index (0 buzzer kind, 1 default
//   duration, 2 default frequency, 3 queue limit, 4 timer clock), always
//   ready; write only while no item is in flight.
//   Sequence: an item passes S_DECIDE and S_FINISH; a tick that starts a queued
//   beep adds S_POP, and a passive tone with a nonzero frequency adds the two
//   28-step divisions of the shared restoring divider.
//   Throughput: one item in flight; s_ready rises again once the result is
//   in the output register. A stalled m_ channel holds the result; the next
//   finished item waits in the controller until the output register frees.
//   Reset: defaults restored, queue empty, tone silent, timer values zero.
`default_nettype none

module queued_beep_tone_controller #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [qbtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qbtc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [qbtc_pkg::DUR_W-1:0]      s_duration_ms,
    input  wire logic [qbtc_pkg::FREQ_W-1:0]     s_freq_hz,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_tone_on,
    output logic      [qbtc_pkg::TV_W-1:0]       m_prescale_value,
    output logic      [qbtc_pkg::TV_W-1:0]       m_reload_value,
    output logic      [qbtc_pkg::CMP_W-1:0]      m_compare_value,
    output logic                                 m_request_dropped,
    output logic                                 m_freq_error,
    output logic      [qbtc_pkg::CNT_W-1:0]      m_pending_count
);
    import qbtc_pkg::*;

    qbtc_cmd_t    cmd;
    qbtc_status_t st;

    assign cfg_ready = 1'b1;

    qbtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    qbtc_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_mode            (s_mode),
        .s_duration_ms     (s_duration_ms),
        .s_freq_hz         (s_freq_hz),
        .cmd               (cmd),
        .st                (st),
        .m_tone_on         (m_tone_on),
        .m_prescale_value  (m_prescale_value),
        .m_reload_value    (m_reload_value),
        .m_compare_value   (m_compare_value),
        .m_request_dropped (m_request_dropped),
        .m_freq_error      (m_freq_error),
        .m_pending_count   (m_pending_count)
    );

endmodule

`default_nettype wire

/* src/qbtc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qbtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/qbtc_div.sv */
// Restoring divider, one quotient bit per cycle, for the tone timer values.
// Depends on qbtc_pkg for operand widths.
`default_nettype none

module qbtc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [qbtc_pkg::NUM_W-1:0] num,
    input  wire logic [qbtc_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic      [qbtc_pkg::NUM_W-1:0] quot
);
    import qbtc_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W:0]    diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= num;
            den_reg  <= den;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg  <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

/* src/qbtc_datapath.sv */
// Datapath: configuration registers, beep queue, countdown and timer values.
// Depends on qbtc_pkg, qbtc_ram and qbtc_div; driven by qbtc_ctrl commands.
`default_nettype none

module qbtc_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_write,
    input  wire logic [qbtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qbtc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_mode,
    input  wire logic [qbtc_pkg::DUR_W-1:0]      s_duration_ms,
    input  wire logic [qbtc_pkg::FREQ_W-1:0]     s_freq_hz,
    input  wire qbtc_pkg::qbtc_cmd_t             cmd,
    output qbtc_pkg::qbtc_status_t               st,
    output logic                                 m_tone_on,
    output logic      [qbtc_pkg::TV_W-1:0]       m_prescale_value,
    output logic      [qbtc_pkg::TV_W-1:0]       m_reload_value,
    output logic      [qbtc_pkg::CMP_W-1:0]      m_compare_value,
    output logic                                 m_request_dropped,
    output logic                                 m_freq_error,
    output logic      [qbtc_pkg::CNT_W-1:0]      m_pending_count
);
    import qbtc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [8:0]    DEPTH_CAP = 9'(QUEUE_DEPTH);

    logic              kind_reg;
    logic [DUR_W-1:0]  def_dur_reg;
    logic [FREQ_W-1:0] def_freq_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [NUM_W-1:0]  clock_hz_reg;

    logic              mode_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [NUM_W-1:0]  q_reg;

    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]  waiting_reg;
    logic [DUR_W-1:0]  remaining_reg;
    logic              sounding_reg;
    logic [TV_W-1:0]   prescale_reg;
    logic [TV_W-1:0]   reload_reg;
    logic [CMP_W-1:0]  compare_reg;
    logic              dropped_reg;
    logic              ferr_reg;

    logic              is_req;
    logic              room;
    logic              req_start;
    logic              req_push;
    logic              req_drop;
    logic              tick_act;
    logic [DUR_W-1:0]  rem_dec;
    logic              tick_end;
    logic              tick_pop;

    logic [ENTRY_W-1:0] rd_data;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [DEN_W-1:0]   prescaler;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic [TV_W-1:0]    period_m1;

    assign is_req    = mode_reg == MODE_REQUEST;
    assign room      = ({4'b0, waiting_reg} < DEPTH_CAP) && (waiting_reg < limit_reg);
    assign req_start = is_req && !sounding_reg;
    assign req_push  = is_req && sounding_reg && room;
    assign req_drop  = is_req && sounding_reg && !room;
    assign tick_act  = !is_req && sounding_reg;
    assign rem_dec   = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;
    assign tick_end  = tick_act && rem_dec == '0;
    assign tick_pop  = tick_end && waiting_reg != '0;

    assign prescaler = DEN_W'({4'b0, q_reg[NUM_W-1:16]}) + 1'b1;
    assign div_num   = cmd.div_sel ? q_reg : clock_hz_reg;
    assign div_den   = cmd.div_sel ? prescaler : freq_reg;
    assign period_m1 = div_quot[TV_W-1:0] - 1'b1;

    assign st.start_tone = req_start;
    assign st.pop        = tick_pop;
    assign st.passive    = kind_reg == KIND_PASSIVE;
    assign st.freq_zero  = freq_reg == '0;
    assign st.div_done   = div_done;

    qbtc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (cmd.decide && req_push),
        .wr_addr (wr_ptr_reg),
        .wr_data ({dur_reg, freq_reg}),
        .rd_en   (cmd.decide && tick_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    qbtc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= RST_BUZZER_KIND;
            def_dur_reg   <= RST_DEF_DUR;
            def_freq_reg  <= RST_DEF_FREQ;
            limit_reg     <= RST_QUEUE_LIMIT;
            clock_hz_reg  <= RST_CLOCK_HZ;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            waiting_reg   <= '0;
            remaining_reg <= '0;
            sounding_reg  <= 1'b0;
            prescale_reg  <= '0;
            reload_reg    <= '0;
            compare_reg   <= '0;
            dropped_reg   <= 1'b0;
            ferr_reg      <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_BUZZER_KIND:  kind_reg     <= cfg_data[0];
                    REG_DEF_DURATION: def_dur_reg  <= cfg_data[DUR_W-1:0];
                    REG_DEF_FREQ:     def_freq_reg <= cfg_data[FREQ_W-1:0];
                    REG_QUEUE_LIMIT:  limit_reg    <= cfg_data[CNT_W-1:0];
                    REG_TIMER_CLOCK:  clock_hz_reg <= cfg_data[NUM_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.capture) begin
                dropped_reg <= 1'b0;
                ferr_reg    <= 1'b0;
            end
            if (cmd.decide) begin
                if (req_start) begin
                    sounding_reg  <= 1'b1;
                    remaining_reg <= dur_reg;
                end
                if (req_push) begin
                    wr_ptr_reg  <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
                    waiting_reg <= waiting_reg + 1'b1;
                end
                if (req_drop) begin
                    dropped_reg <= 1'b1;
                end
                if (tick_act) begin
                    remaining_reg <= rem_dec;
                end
                if (tick_end) begin
                    sounding_reg <= 1'b0;
                    if (kind_reg == KIND_PASSIVE) begin
                        compare_reg <= '0;
                    end
                end
                if (tick_pop) begin
                    rd_ptr_reg  <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
                    waiting_reg <= waiting_reg - 1'b1;
                end
            end
            if (cmd.pop_load) begin
                sounding_reg  <= 1'b1;
                remaining_reg <= rd_data[ENTRY_W-1:FREQ_W];
            end
            if (cmd.set_ferr) begin
                ferr_reg <= 1'b1;
            end
            if (cmd.load_timer) begin
                if (div_quot == '0) begin
                    ferr_reg <= 1'b1;
                end else begin
                    prescale_reg <= TV_W'(q_reg[NUM_W-1:16]);
                    reload_reg   <= period_m1;
                    compare_reg  <= period_m1[TV_W-1:1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_mode;
            dur_reg  <= (s_duration_ms == '0) ? def_dur_reg : s_duration_ms;
            freq_reg <= (s_freq_hz == '0) ? def_freq_reg : s_freq_hz;
        end
        if (cmd.pop_load) begin
            freq_reg <= rd_data[FREQ_W-1:0];
        end
        if (cmd.take_q) begin
            q_reg <= div_quot;
        end
        if (cmd.load_out) begin
            m_tone_on         <= sounding_reg;
            m_prescale_value  <= prescale_reg;
            m_reload_value    <= reload_reg;
            m_compare_value   <= compare_reg;
            m_request_dropped <= dropped_reg;
            m_freq_error      <= ferr_reg;
            m_pending_count   <= waiting_reg;
        end
    end

endmodule

`default_nettype wire

/* src/qbtc_ctrl.sv */
// Controller: sequences one item through decode, the queue read and two divisions when
// needed, and the output register. Depends on qbtc_pkg.
`default_nettype none

module qbtc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire qbtc_pkg::qbtc_status_t st,
    output qbtc_pkg::qbtc_cmd_t        cmd
);
    import qbtc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_POP,
        S_TONE,
        S_DIV_Q,
        S_DIV_P_GO,
        S_DIV_P,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (st.start_tone && st.passive) begin
                    state_next = S_TONE;
                end else if (st.pop) begin
                    state_next = S_POP;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = st.passive ? S_TONE : S_FINISH;
            end
            S_TONE: begin
                if (st.freq_zero) begin
                    cmd.set_ferr = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_Q;
                end
            end
            S_DIV_Q: begin
                cmd.take_q = st.div_done;
                if (st.div_done) begin
                    state_next = S_DIV_P_GO;
                end
            end
            S_DIV_P_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_DIV_P;
            end
            S_DIV_P: begin
                cmd.div_sel    = 1'b1;
                cmd.load_timer = st.div_done;
                if (st.div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.load_out = !m_valid_reg || m_ready;
                if (cmd.load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* sim/tb_queued_beep_tone_controller.sv */
`timescale 1ns / 100ps
// Testbench for queued_beep_tone_controller: directed and random beep requests and ticks,
// each result checked against a behavioral model of the beep queue and the tone timer.
// Depends on qbtc_pkg and the block's RTL.

module tb_queued_beep_tone_controller;
    import qbtc_pkg::*;

    localparam int QDEPTH          = 16;
    localparam int PRESSURE_CYCLES = 400;
    localparam int QUIET_LIMIT     = 5000;
    localparam int END_CYCLES      = 80;

    localparam logic MODE_TICK   = 1'b1;
    localparam logic KIND_ACTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic              mode;
        logic [DUR_W-1:0]  duration;
        logic [FREQ_W-1:0] freq;
    } beep_item_t;

    typedef struct packed {
        logic             tone_on;
        logic [TV_W-1:0]  prescale;
        logic [TV_W-1:0]  reload;
        logic [CMP_W-1:0] compare;
        logic             dropped;
        logic             freq_error;
        logic [CNT_W-1:0] pending;
    } tone_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_mode = 1'b0;
    logic [DUR_W-1:0]      s_duration_ms = '0;
    logic [FREQ_W-1:0]     s_freq_hz = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_tone_on;
    logic [TV_W-1:0]       m_prescale_value;
    logic [TV_W-1:0]       m_reload_value;
    logic [CMP_W-1:0]      m_compare_value;
    logic                  m_request_dropped;
    logic                  m_freq_error;
    logic [CNT_W-1:0]      m_pending_count;

    queued_beep_tone_controller #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_duration_ms(s_duration_ms),
        .s_freq_hz(s_freq_hz),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_tone_on(m_tone_on),
        .m_prescale_value(m_prescale_value),
        .m_reload_value(m_reload_value),
        .m_compare_value(m_compare_value),
        .m_request_dropped(m_request_dropped),
        .m_freq_error(m_freq_error),
        .m_pending_count(m_pending_count)
    );

    // configuration copy
    logic              kind_cfg  = RST_BUZZER_KIND;
    logic [DUR_W-1:0]  ddur_cfg  = RST_DEF_DUR;
    logic [FREQ_W-1:0] dfreq_cfg = RST_DEF_FREQ;
    logic [CNT_W-1:0]  limit_cfg = RST_QUEUE_LIMIT;
    logic [NUM_W-1:0]  clk_cfg   = RST_CLOCK_HZ;

    // beep queue and tone state
    logic [ENTRY_W-1:0] beep_fifo [QDEPTH];
    int unsigned        fifo_rd = 0;
    int unsigned        fifo_wr = 0;
    int unsigned        fifo_waiting = 0;
    logic [DUR_W-1:0]   tone_left = '0;
    logic               tone_sounding = 1'b0;
    logic [TV_W-1:0]    tv_pre = '0;
    logic [TV_W-1:0]    tv_rel = '0;
    logic [CMP_W-1:0]   tv_cmp = '0;

    beep_item_t   beep_items[$];
    tone_result_t tone_expected[$];
    int unsigned  errors = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    bit           pressure_req = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  quiet_cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic logic start_tone(input logic [DUR_W-1:0] d, input logic [FREQ_W-1:0] f);
        int unsigned q;
        int unsigned p;
        int unsigned period;
        tone_sounding = 1'b1;
        tone_left = d;
        if (kind_cfg != KIND_PASSIVE) return 1'b0;
        if (f == 0) return 1'b1;
        q = clk_cfg / f;
        p = q / 65536 + 1;
        if (p > 32'hFFFF) return 1'b1;
        period = q / p;
        if (period == 0) return 1'b1;
        tv_pre = TV_W'(p - 1);
        tv_rel = TV_W'(period - 1);
        tv_cmp = CMP_W'((period - 1) / 2);
        return 1'b0;
    endfunction

    task automatic predict_tone(input beep_item_t it, output tone_result_t r);
        logic [DUR_W-1:0]   d;
        logic [FREQ_W-1:0]  f;
        logic               drop;
        logic               ferr;
        int unsigned        lim;
        logic [ENTRY_W-1:0] e;
        d = it.duration;
        f = it.freq;
        drop = 1'b0;
        ferr = 1'b0;
        if (it.mode == MODE_REQUEST) begin
            lim = (limit_cfg > QDEPTH) ? QDEPTH : limit_cfg;
            if (d == 0) d = ddur_cfg;
            if (f == 0) f = dfreq_cfg;
            if (!tone_sounding) begin
                ferr = start_tone(d, f);
            end else if (fifo_waiting < lim) begin
                beep_fifo[fifo_wr] = {d, f};
                fifo_wr = (fifo_wr + 1) % QDEPTH;
                fifo_waiting++;
            end else begin
                drop = 1'b1;
            end
        end else if (tone_sounding) begin
            if (tone_left > 0) tone_left--;
            if (tone_left == 0) begin
                tone_sounding = 1'b0;
                if (kind_cfg == KIND_PASSIVE) tv_cmp = '0;
                if (fifo_waiting > 0) begin
                    e = beep_fifo[fifo_rd];
                    fifo_rd = (fifo_rd + 1) % QDEPTH;
                    fifo_waiting--;
                    ferr = start_tone(e[ENTRY_W-1:FREQ_W], e[FREQ_W-1:0]);
                end
            end
        end
        r.tone_on    = tone_sounding;
        r.prescale   = tv_pre;
        r.reload     = tv_rel;
        r.compare    = tv_cmp;
        r.dropped    = drop;
        r.freq_error = ferr;
        r.pending    = CNT_W'(fifo_waiting);
    endtask

    // driver: offer queued items, hold until transfer
    always @(posedge aclk) begin
        beep_item_t   it;
        tone_result_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.mode = s_mode;
                it.duration = s_duration_ms;
                it.freq = s_freq_hz;
                predict_tone(it, r);
                tone_expected.push_back(r);
            end
            if (!s_valid || s_ready) begin
                if (beep_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = beep_items.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= it.mode;
                    s_duration_ms <= it.duration;
                    s_freq_hz <= it.freq;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (pressure_req) begin
            pressure_req = 1'b0;
            hold_left = PRESSURE_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        tone_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tone_expected.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = tone_expected.pop_front();
                if (m_tone_on !== want.tone_on)
                    report_mismatch($sformatf("tone_on %0h exp %0h", m_tone_on, want.tone_on));
                if (m_prescale_value !== want.prescale)
                    report_mismatch($sformatf("prescale %0h exp %0h",
                        m_prescale_value, want.prescale));
                if (m_reload_value !== want.reload)
                    report_mismatch($sformatf("reload %0h exp %0h",
                        m_reload_value, want.reload));
                if (m_compare_value !== want.compare)
                    report_mismatch($sformatf("compare %0h exp %0h",
                        m_compare_value, want.compare));
                if (m_request_dropped !== want.dropped)
                    report_mismatch($sformatf("dropped %0h exp %0h",
                        m_request_dropped, want.dropped));
                if (m_freq_error !== want.freq_error)
                    report_mismatch($sformatf("freq_error %0h exp %0h",
                        m_freq_error, want.freq_error));
                if (m_pending_count !== want.pending)
                    report_mismatch($sformatf("pending %0d exp %0d",
                        m_pending_count, want.pending));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BUZZER_KIND:  kind_cfg = data[0];
            REG_DEF_DURATION: ddur_cfg = data[DUR_W-1:0];
            REG_DEF_FREQ:     dfreq_cfg = data[FREQ_W-1:0];
            REG_QUEUE_LIMIT:  limit_cfg = data[CNT_W-1:0];
            REG_TIMER_CLOCK:  clk_cfg = data[NUM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [DUR_W-1:0] d, input logic [FREQ_W-1:0] f);
        beep_items.push_back('{MODE_REQUEST, d, f});
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) beep_items.push_back('{MODE_TICK, DUR_W'($urandom), FREQ_W'($urandom)});
    endtask

    task automatic queue_random_items(input int n);
        beep_item_t  it;
        int unsigned r;
        repeat (n) begin
            it.mode = ($urandom_range(99) < 55) ? MODE_TICK : MODE_REQUEST;
            r = $urandom_range(999);
            if (r < 5)
                it.duration = DUR_W'($urandom);
            else if (r < 100)
                it.duration = '0;
            else
                it.duration = DUR_W'($urandom_range(1, 4));
            r = $urandom_range(99);
            if (r < 10)
                it.freq = '0;
            else if (r < 30)
                it.freq = FREQ_W'($urandom_range(1, 50));
            else
                it.freq = FREQ_W'($urandom);
            beep_items.push_back(it);
        end
    endtask

    task automatic drain_block();
        while (beep_items.size() != 0 || s_valid || tone_expected.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_setting(input logic kind, input int ddur, input int dfreq,
                               input int lim, input int clk_hz, input int sidle,
                               input int rstall, input int n, input bit press);
        write_reg(REG_BUZZER_KIND, CFG_DATA_W'(kind));
        write_reg(REG_DEF_DURATION, CFG_DATA_W'(ddur));
        write_reg(REG_DEF_FREQ, CFG_DATA_W'(dfreq));
        write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_TIMER_CLOCK, CFG_DATA_W'(clk_hz));
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        queue_random_items(n);
        if (press) pressure_req = 1'b1;
        drain_block();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // passive through a too-wide write, default tone at the reset clock
        write_reg(REG_BUZZER_KIND, 28'hFFFFFFF);
        write_reg(REG_DEF_DURATION, 3);
        queue_ticks(1);
        queue_request(2, 0);
        queue_request(0, 0);
        queue_request(1, 16'hFFFF);
        queue_ticks(7);
        drain_block();

        // no queue room and a stopped timer clock
        write_reg(REG_QUEUE_LIMIT, 0);
        write_reg(REG_TIMER_CLOCK, 0);
        queue_request(3, 500);
        queue_request(16'hFFFF, 16'hFFFF);
        queue_request(16'hAAAA, 16'h5555);
        queue_request(16'h5555, 16'hAAAA);
        queue_ticks(3);
        drain_block();

        // zero-length beep, tone above the clock, capped limit, spare indexes
        write_reg(REG_TIMER_CLOCK, 1000);
        write_reg(REG_QUEUE_LIMIT, 28'h3F);
        write_reg(REG_DEF_DURATION, 0);
        write_reg(REG_SPARE_LAST, 28'hFFFFFFF);
        write_reg(REG_SPARE_FIRST, 0);
        queue_request(0, 1001);
        queue_ticks(1);
        queue_request(1, 1000);
        queue_ticks(1);
        drain_block();

        // largest clock, then lower the limit under the queued count
        write_reg(REG_TIMER_CLOCK, 28'hFFFFFFF);
        write_reg(REG_QUEUE_LIMIT, 16);
        queue_request(4, 1);
        queue_request(1, 2);
        queue_request(1, 3);
        drain_block();
        write_reg(REG_QUEUE_LIMIT, 1);
        queue_request(1, 4);
        queue_ticks(6);
        drain_block();

        run_setting(KIND_PASSIVE, 3, 1000, 10, 100000000, 0, 0, 200, 1'b0);
        run_setting(KIND_ACTIVE, 5, 440, 16, 100000000, 66, 0, 200, 1'b0);
        run_setting(KIND_PASSIVE, 1, 65535, 1, 1, 0, 66, 200, 1'b0);
        run_setting(KIND_PASSIVE, 2, 1, 4, 28'hFFFFFFF, 8, 8, 200, 1'b0);
        run_setting(KIND_PASSIVE, 0, 2000, 31, 200000000, 0, 0, 200, 1'b1);
        run_setting(KIND_PASSIVE, 4, 30000, 2, 65536, 66, 0, 200, 1'b0);
        run_setting(KIND_PASSIVE, 1, 500, 0, 1000000, 0, 66, 200, 1'b0);
        run_setting(KIND_PASSIVE, 3, 1234, 16, 50000, 8, 8, 200, 1'b0);
        run_setting(KIND_ACTIVE, 2, 1, 8, 100000000, 0, 0, 200, 1'b0);
        run_setting(KIND_PASSIVE, 65535, 1, 5, 1, 0, 0, 60, 1'b0);

        repeat (END_CYCLES) @(posedge aclk);
        if (tone_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", tone_expected.size()));
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
